FILE: sv/plasma_pixel_generator_assert.svh
// ============================================================================
// Plasma pixel generator assertion macros
// Shared concurrent assertion forms for the plasma pixel generator RTL.
// ============================================================================
`ifndef PLASMA_PIXEL_GENERATOR_ASSERT_SVH
`define PLASMA_PIXEL_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PPG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("plasma pixel generator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define PPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("plasma pixel generator: next-cycle check failed");

`endif

FILE: sv/ppg_pkg.sv
// ============================================================================
// Plasma pixel generator package
// Sine table, lookup functions and fixed constants of the plasma generator.
// ============================================================================
package ppg_pkg;

    // Field widths
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int CHAN_W  = 8;
    localparam int PHASE_W = 8;
    localparam int CFG_W   = 8;

    // Frame size and compare width (frame bounds go up to 8191)
    localparam int BOUND_W = 13;
    localparam int COLS    = 320;
    localparam int ROWS    = 180;

    // Register reset value, fixed colors, color mask and cosine offset
    localparam logic [CFG_W-1:0]  FRAMES_PER_STEP_RST = 8'd15;
    localparam logic [CHAN_W-1:0] BLUE_LEVEL          = 8'd120;
    localparam logic [CHAN_W-1:0] CHAN_MASK           = 8'hFC;
    localparam logic [PHASE_W-1:0] COS_OFFSET         = 8'd64;

    typedef logic [7:0] t_byte;

    // Input beat operations
    typedef enum logic {
        OP_PIXEL      = 1'b0,
        OP_FRAME_TICK = 1'b1
    } t_op;

    // One full period of the sine, offset binary, 256 points
    localparam t_byte SINE_TAB [256] = '{
        8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd184, 8'd187, 8'd190, 8'd193, 8'd195,
        8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215,
        8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
        8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244,
        8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
        8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
        8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
        8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
        8'd245, 8'd244, 8'd242, 8'd241, 8'd239, 8'd238, 8'd236, 8'd235,
        8'd233, 8'd231, 8'd229, 8'd228, 8'd226, 8'd224, 8'd221, 8'd219,
        8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
        8'd198, 8'd195, 8'd193, 8'd190, 8'd187, 8'd184, 8'd182, 8'd179,
        8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
        8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130,
        8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd111, 8'd108, 8'd105,
        8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
        8'd78,  8'd75,  8'd72,  8'd70,  8'd67,  8'd64,  8'd61,  8'd59,
        8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd41,  8'd39,
        8'd37,  8'd35,  8'd33,  8'd30,  8'd28,  8'd26,  8'd25,  8'd23,
        8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
        8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
        8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
        8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
        8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
        8'd21,  8'd23,  8'd25,  8'd26,  8'd28,  8'd30,  8'd33,  8'd35,
        8'd37,  8'd39,  8'd41,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
        8'd56,  8'd59,  8'd61,  8'd64,  8'd67,  8'd70,  8'd72,  8'd75,
        8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
        8'd102, 8'd105, 8'd108, 8'd111, 8'd115, 8'd118, 8'd121, 8'd124
    };

    // Sine lookup, index wraps modulo 256
    function automatic t_byte sin_lut(input t_byte x);
        return SINE_TAB[x];
    endfunction

    // Cosine is the sine a quarter period ahead
    function automatic t_byte cos_lut(input t_byte x);
        t_byte idx;
        idx = x + COS_OFFSET;
        return SINE_TAB[idx];
    endfunction

endpackage

FILE: sv/plasma_pixel_generator.sv
// ============================================================================
// Plasma pixel generator
// Animated sine-table plasma color for each half-resolution pixel, with
// frame-tick driven phase animation.
// ============================================================================
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------
//  input   | in        | i_valid / o_stall       | i_op, i_col, i_row
//  output  | out       | o_valid / i_stall       | o_red, o_green, o_blue
//  config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_data
//
//  One beat is accepted per cycle while o_stall is low; a pixel passes
//  five register stages on its way to the output (capture, phase terms,
//  t1, palette index, color; the input beat itself loads the capture
//  stage). Frame ticks and off-frame pixels leave no result.
//  Phases update at the edge that accepts the frame tick that ends a step,
//  and each pixel takes its phases at its own input beat. Reset is synchronous, active low.
//  A stage holds only while the stage after it is full and held, so an
//  output stall backs up through the stages and finally raises o_stall.
//
module plasma_pixel_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_op,
    input  logic [ppg_pkg::COL_W-1:0]      i_col,
    input  logic [ppg_pkg::ROW_W-1:0]      i_row,
    // output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ppg_pkg::CHAN_W-1:0]     o_red,
    output logic [ppg_pkg::CHAN_W-1:0]     o_green,
    output logic [ppg_pkg::CHAN_W-1:0]     o_blue,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ppg_pkg::CFG_W-1:0]      i_cfg_data
);

    `include "plasma_pixel_generator_assert.svh"

    // ------------------------------------------------------------------
    // Animation state
    // ------------------------------------------------------------------
    logic [ppg_pkg::CFG_W-1:0]   r_frames_per_step;
    logic [ppg_pkg::PHASE_W-1:0] r_phase_u, n_phase_u;
    logic [ppg_pkg::PHASE_W-1:0] r_phase_v, n_phase_v;
    logic [ppg_pkg::PHASE_W-1:0] r_frame_cnt, n_frame_cnt;
    logic [ppg_pkg::PHASE_W-1:0] frame_inc;

    // Pipeline valids and stage enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;
    logic in_accept, tick_accept, pix_in_frame, phase_step;

    // Stage 1: captured pixel (low column bits only) and phases
    logic [7:0]                  r_s1_col;
    logic [ppg_pkg::ROW_W-1:0]   r_s1_row;
    logic [ppg_pkg::PHASE_W-1:0] r_s1_pu;
    logic [ppg_pkg::PHASE_W-1:0] r_s1_pv;
    // Stage 2: first lookups
    logic [7:0] r_s2_col, r_s2_a, r_s2_snu, r_s2_t2;
    // Stage 3: both table indexes
    logic [7:0] r_s3_t1, r_s3_t2;
    // Stage 4: palette index
    logic [7:0] r_s4_p;
    // Stage 5: color
    logic [ppg_pkg::CHAN_W-1:0] r_red, r_green;

    logic [7:0] n_s2_a, n_s2_snu, n_s2_t2, n_s3_t1, n_s4_p, w_term, c_val;
    logic [7:0] pv_row, cos_pv;

    // Stall chain: a stage moves when it is empty or its successor moves
    assign en5 = !r_v5 || !i_stall;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_stall      = !en1;
    assign in_accept    = i_valid && en1;
    assign tick_accept  = in_accept && (i_op == ppg_pkg::OP_FRAME_TICK);
    assign pix_in_frame = (ppg_pkg::BOUND_W'(i_col) < ppg_pkg::BOUND_W'(ppg_pkg::COLS))
                       && (ppg_pkg::BOUND_W'(i_row) < ppg_pkg::BOUND_W'(ppg_pkg::ROWS));

    assign o_cfg_ready = 1'b1;

    // Frame counter and phase advance
    always_comb begin
        frame_inc   = r_frame_cnt + 8'd1;
        phase_step  = tick_accept && (frame_inc == r_frames_per_step);
        n_frame_cnt = r_frame_cnt;
        n_phase_u   = r_phase_u;
        n_phase_v   = r_phase_v;
        if (tick_accept) begin
            n_frame_cnt = frame_inc;
        end
        if (phase_step) begin
            n_frame_cnt = '0;
            n_phase_u   = r_phase_u - 8'd1;
            n_phase_v   = r_phase_v + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_per_step <= ppg_pkg::FRAMES_PER_STEP_RST;
            r_frame_cnt       <= '0;
            r_phase_u         <= '0;
            r_phase_v         <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_frames_per_step <= i_cfg_data;
            end
            r_frame_cnt <= n_frame_cnt;
            r_phase_u   <= n_phase_u;
            r_phase_v   <= n_phase_v;
        end
    end

    // ------------------------------------------------------------------
    // Datapath, low eight bits throughout
    // ------------------------------------------------------------------
    always_comb begin
        // stage 2 terms
        cos_pv   = ppg_pkg::cos_lut(r_s1_pv);
        w_term   = {2'b00, cos_pv[7:2]};
        n_s2_a   = r_s1_pu - w_term + r_s1_row;
        n_s2_snu = ppg_pkg::sin_lut(r_s1_pu);
        pv_row   = r_s1_pv + r_s1_row;
        n_s2_t2  = r_s1_row + ppg_pkg::cos_lut(pv_row);
        // stage 3: t1 = col + S(a) - S(u)
        n_s3_t1  = r_s2_col + ppg_pkg::sin_lut(r_s2_a) - r_s2_snu;
        // stage 4: odd palette index
        c_val    = ppg_pkg::sin_lut(r_s3_t1) - ppg_pkg::cos_lut(r_s3_t2)
                 - ppg_pkg::cos_lut(r_s3_t1);
        n_s4_p   = {c_val[7:1], 1'b1};
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= in_accept && (i_op == ppg_pkg::OP_PIXEL) && pix_in_frame;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_col <= i_col[7:0];
            r_s1_row <= i_row;
            r_s1_pu  <= r_phase_u;
            r_s1_pv  <= r_phase_v;
        end
        if (en2) begin
            r_s2_col <= r_s1_col;
            r_s2_a   <= n_s2_a;
            r_s2_snu <= n_s2_snu;
            r_s2_t2  <= n_s2_t2;
        end
        if (en3) begin
            r_s3_t1 <= n_s3_t1;
            r_s3_t2 <= r_s2_t2;
        end
        if (en4) begin
            r_s4_p <= n_s4_p;
        end
        if (en5) begin
            r_red   <= ppg_pkg::cos_lut(r_s4_p) & ppg_pkg::CHAN_MASK;
            r_green <= ppg_pkg::sin_lut(r_s4_p) & ppg_pkg::CHAN_MASK;
        end
    end

    assign o_valid = r_v5;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = ppg_pkg::BLUE_LEVEL;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PPG_ASSERT_NOW(a_color_grid, i_clk, i_rst_n, o_valid, (o_red[1:0] == 2'b00) && (o_green[1:0] == 2'b00))
    `PPG_ASSERT_NOW(a_empty_entry_no_stall, i_clk, i_rst_n, !r_v1, !o_stall)
    `PPG_ASSERT_NEXT(a_phase_advance, i_clk, i_rst_n, phase_step, (r_phase_u + 8'd1 == $past(r_phase_u)) && (r_phase_v == $past(r_phase_v) + 8'd1) && (r_frame_cnt == 8'd0))
    `PPG_ASSERT_NEXT(a_phase_hold, i_clk, i_rst_n, !tick_accept, $stable(r_phase_u) && $stable(r_phase_v) && $stable(r_frame_cnt))
    `PPG_ASSERT_NEXT(a_stage_kept, i_clk, i_rst_n, r_v4 && r_v5 && i_stall, r_v4 && r_v5)

endmodule
